### src/pnpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pnpm_pkg;

   // Longest name kept by default; further characters are dropped.
   localparam int unsigned NAME_MAX_CHARS_DEFAULT = 255;

   localparam int unsigned PATTERN_COUNT = 11;
   localparam int unsigned PATTERN_SLOTS = 17;
   localparam int unsigned SLOT_IDX_W    = 5;
   localparam int unsigned CHAR_W        = 16;
   localparam int unsigned LIMIT_W       = 8;
   localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET = 8'd7;

   localparam logic [CHAR_W-1:0] UPPER_FIRST = 16'h0041;
   localparam logic [CHAR_W-1:0] UPPER_LAST  = 16'h005A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

   // Each pattern is right-aligned in its slot vector: the first character sits
   // in the most significant occupied byte, so position p lives at byte len-1-p.
   localparam logic [PATTERN_SLOTS*8-1:0] PATTERN_ROM [PATTERN_COUNT] = '{
      (PATTERN_SLOTS*8)'("\\pipe\\msagent"),
      (PATTERN_SLOTS*8)'("\\pipe\\mserv"),
      (PATTERN_SLOTS*8)'("\\pipe\\status_"),
      (PATTERN_SLOTS*8)'("\\pipe\\mojo."),
      (PATTERN_SLOTS*8)'("\\pipe\\postex_"),
      (PATTERN_SLOTS*8)'("\\pipe\\msf"),
      // The longest pattern fills every slot; it is spelt out byte by byte.
      136'h5c_70_69_70_65_5c_6d_65_74_65_72_70_72_65_74_65_72,
      (PATTERN_SLOTS*8)'("\\pipe\\backdoor"),
      (PATTERN_SLOTS*8)'("\\pipe\\c2"),
      (PATTERN_SLOTS*8)'("\\pipe\\cmd"),
      (PATTERN_SLOTS*8)'("\\pipe\\remote")
   };

   localparam logic [SLOT_IDX_W-1:0] PATTERN_LEN [PATTERN_COUNT] = '{
      5'd13, 5'd11, 5'd13, 5'd11, 5'd13, 5'd9, 5'd17, 5'd14, 5'd8, 5'd9, 5'd12
   };

   typedef struct packed {
      logic [CHAR_W-1:0] name_char;
      logic              last_char;
   } req_word_type;

   typedef struct packed {
      logic suspicious_name;
      logic short_name;
   } rsp_word_type;

endpackage

`default_nettype wire

### src/pipe_name_pattern_matcher.sv
// Latency: a result word is loaded into the output register in the cycle after the
// last character of a name is accepted; other characters produce no word.
// Throughput: one character word per cycle, bounded only by the single output
// register, which stalls the input while a finished result is held back.
// Reset (synchronous, active high): position counter to zero, every pattern
// marked as still matching, short-name limit to 7, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module pipe_name_pattern_matcher #(
   parameter int unsigned NAME_MAX_CHARS = pnpm_pkg::NAME_MAX_CHARS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  pnpm_pkg::req_word_type     req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output pnpm_pkg::rsp_word_type           rsp_data,
   input  wire                              csr_wr_en,
   input  wire  [pnpm_pkg::LIMIT_W-1:0]     csr_wr_data
);

   import pnpm_pkg::*;

   // The position counter must hold NAME_MAX_CHARS itself.
   localparam int unsigned POS_W = $clog2(NAME_MAX_CHARS + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(NAME_MAX_CHARS);

   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [PATTERN_COUNT-1:0] alive_ff, alive_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic [CHAR_W-1:0]        folded;
   logic                     counting;
   logic [POS_W-1:0]         kept_len;
   logic [PATTERN_COUNT-1:0] mismatch;
   logic [PATTERN_COUNT-1:0] alive_next;
   logic [PATTERN_COUNT-1:0] long_enough;
   logic [SLOT_IDX_W-1:0]    slot_idx [PATTERN_COUNT];

   // The input is held back only while a result sits in the output register
   // and the far side refuses it; otherwise that register drains and refills
   // in the same cycle, so one word per cycle flows through.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Case folding covers ASCII capitals only.
   always_comb begin
      if (req_data.name_char >= UPPER_FIRST && req_data.name_char <= UPPER_LAST) begin
         folded = req_data.name_char + CASE_OFFSET;
      end else begin
         folded = req_data.name_char;
      end
   end

   // Once the counter saturates, characters are neither compared nor counted.
   assign counting = pos_ff < POS_MAX;
   assign kept_len = counting ? pos_ff + POS_W'(1) : pos_ff;

   // All eleven patterns are compared side by side. A pattern only sees the
   // positions it covers; characters beyond its end leave its bit alone.
   always_comb begin
      for (int i = 0; i < PATTERN_COUNT; i++) begin
         slot_idx[i]    = PATTERN_LEN[i] - SLOT_IDX_W'(1) - pos_ff[SLOT_IDX_W-1:0];
         mismatch[i]    = 1'b0;
         if (counting && (pos_ff < POS_W'(PATTERN_LEN[i]))) begin
            mismatch[i] = folded != {8'h00, PATTERN_ROM[i][{slot_idx[i], 3'b000} +: 8]};
         end
         long_enough[i] = kept_len >= POS_W'(PATTERN_LEN[i]);
      end
   end

   assign alive_next = alive_ff & ~mismatch;

   always_comb begin
      pos_in       = pos_ff;
      alive_in     = alive_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         if (req_data.last_char) begin
            // A pattern matches when it survived every position and the
            // name was long enough to cover all of it.
            rsp_data_in.suspicious_name = |(alive_next & long_enough);
            rsp_data_in.short_name      = ({{LIMIT_W{1'b0}}, kept_len}
                                           <= {{POS_W{1'b0}}, limit_ff});
            rsp_valid_in = 1'b1;
            pos_in       = '0;
            alive_in     = '1;
         end else begin
            pos_in   = kept_len;
            alive_in = alive_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         alive_ff     <= '1;
         limit_ff     <= SHORT_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         alive_ff     <= alive_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // A result only appears as the answer to an accepted last character.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && req_data.last_char))
      else $error("result word without an accepted last character");

   // The per-name state is cleared after every name.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_char) |=> (pos_ff == '0 && alive_ff == '1))
      else $error("per-name state not cleared after a name");

   // The position counter saturates at the name limit.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("position counter beyond the name limit");

   // A pattern once lost within a name never comes back before its end.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_data.last_char) |=> ((alive_ff & ~$past(alive_ff)) == '0))
      else $error("pattern revived within a name");
`endif

endmodule

`default_nettype wire
